FILE: rtl/cpsw_pkg.sv
// ----------------------------------------------------------------------------
// cpsw_pkg: shared types and constants of the clipped planar span writer
// Register indexes, configuration record, controller state and the command
// and status records that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package cpsw_pkg;

    localparam int unsigned ScreenCols = 640;
    localparam int unsigned PageBytes  = 16000;
    localparam int unsigned MaxWrites  = 40;
    localparam int unsigned CntW       = 6;
    localparam int unsigned AddrW      = 5;
    localparam int unsigned DataW      = 32;

    // Register indexes, taken from paddr[4:2].
    localparam logic [2:0] REG_CLIP_LEFT   = 3'd0;
    localparam logic [2:0] REG_CLIP_RIGHT  = 3'd1;
    localparam logic [2:0] REG_CLIP_TOP    = 3'd2;
    localparam logic [2:0] REG_CLIP_BOTTOM = 3'd3;
    localparam logic [2:0] REG_TOP_PAGE    = 3'd4;
    localparam logic [2:0] REG_BANK_SELECT = 3'd5;
    localparam logic [2:0] REG_PLANE_MODE  = 3'd6;

    typedef struct packed {
        logic [9:0] clip_left;
        logic [9:0] clip_right;
        logic [8:0] clip_top;
        logic [8:0] clip_bottom;
        logic       top_page;
        logic       bank_select;
        logic [7:0] plane_mode;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CLIP = 4'b0010,
        S_ADDR = 4'b0100,
        S_RUN  = 4'b1000
    } t_state;

    typedef struct packed {
        logic load;
        logic calc_base;
        logic calc_addr;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic ok;
        logic last;
    } t_status;

endpackage

FILE: rtl/cpsw_regs.sv
// ----------------------------------------------------------------------------
// cpsw_regs: configuration register file
// APB-style slave holding the view window, page, bank and plane mode.
// ----------------------------------------------------------------------------
module cpsw_regs import cpsw_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    output logic [DataW-1:0] prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[4:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clip_left   <= 10'd0;
            r_cfg.clip_right  <= 10'd639;
            r_cfg.clip_top    <= 9'd0;
            r_cfg.clip_bottom <= 9'd399;
            r_cfg.top_page    <= 1'b0;
            r_cfg.bank_select <= 1'b0;
            r_cfg.plane_mode  <= 8'h80;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_CLIP_LEFT:   r_cfg.clip_left   <= pwdata[9:0];
                REG_CLIP_RIGHT:  r_cfg.clip_right  <= pwdata[9:0];
                REG_CLIP_TOP:    r_cfg.clip_top    <= pwdata[8:0];
                REG_CLIP_BOTTOM: r_cfg.clip_bottom <= pwdata[8:0];
                REG_TOP_PAGE:    r_cfg.top_page    <= pwdata[0];
                REG_BANK_SELECT: r_cfg.bank_select <= pwdata[0];
                REG_PLANE_MODE:  r_cfg.plane_mode  <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_CLIP_LEFT:   prdata = DataW'(r_cfg.clip_left);
            REG_CLIP_RIGHT:  prdata = DataW'(r_cfg.clip_right);
            REG_CLIP_TOP:    prdata = DataW'(r_cfg.clip_top);
            REG_CLIP_BOTTOM: prdata = DataW'(r_cfg.clip_bottom);
            REG_TOP_PAGE:    prdata = DataW'(r_cfg.top_page);
            REG_BANK_SELECT: prdata = DataW'(r_cfg.bank_select);
            REG_PLANE_MODE:  prdata = DataW'(r_cfg.plane_mode);
            default:         prdata = '0;
        endcase
    end

endmodule

FILE: rtl/cpsw_ctrl.sv
// ----------------------------------------------------------------------------
// cpsw_ctrl: span controller
// Sequences clipping, address set-up and the word-write burst of one span.
// ----------------------------------------------------------------------------
module cpsw_ctrl import cpsw_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CLIP;
                end
            end
            S_CLIP: begin
                // An off-window row or an empty span ends here without writes.
                if (i_status.ok) begin
                    o_cmd.calc_base = 1'b1;
                    n_state         = S_ADDR;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_ADDR: begin
                o_cmd.calc_addr = 1'b1;
                n_state         = S_RUN;
            end
            S_RUN: begin
                o_cmd.emit = 1'b1;
                if (i_status.last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/cpsw_datapath.sv
// ----------------------------------------------------------------------------
// cpsw_datapath: clipping, address arithmetic and write generation
// Holds the clipped span, the row base address and the word walker that
// produces one masked word write per cycle.
// ----------------------------------------------------------------------------
module cpsw_datapath import cpsw_pkg::*; #(
    parameter int unsigned ROW_BYTES = 80
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    input  t_cfg               i_cfg,
    input  logic signed [15:0] i_x_start,
    input  logic signed [15:0] i_x_end,
    input  logic signed [15:0] i_row,
    input  logic [7:0]         i_color,
    output logic               o_valid,
    output logic [14:0]        o_word_offset,
    output logic               o_bank,
    output logic [7:0]         o_mask_even,
    output logic [7:0]         o_mask_odd,
    output logic [3:0]         o_plane_enable,
    output logic [3:0]         o_plane_data,
    output logic               o_last_write
);

    localparam int unsigned RightMaxI = (ROW_BYTES * 8 - 1 < ScreenCols - 1) ?
                                        ROW_BYTES * 8 - 1 : ScreenCols - 1;
    localparam logic [9:0]  RightMax  = 10'(RightMaxI);
    localparam int unsigned BaseW     = $clog2(511 * ROW_BYTES + PageBytes + 128);
    localparam logic [BaseW-1:0] RowBytesC = BaseW'(ROW_BYTES);
    localparam logic [BaseW-1:0] PageOff   = BaseW'(PageBytes);
    localparam logic [BaseW-1:0] CapDiff   = BaseW'(MaxWrites - 1);

    // Pixel mask of byte column c within the inclusive span x1..x2.
    function automatic logic [7:0] byte_mask(logic signed [7:0] c,
                                             logic [9:0] x1, logic [9:0] x2);
        logic signed [7:0] c1;
        logic signed [7:0] c2;
        logic [7:0]        m;
        c1 = $signed({1'b0, x1[9:3]});
        c2 = $signed({1'b0, x2[9:3]});
        m  = 8'hff;
        if (c < c1 || c > c2) begin
            m = 8'h00;
        end else begin
            if (c == c1) m = m & (8'hff >> x1[2:0]);
            if (c == c2) m = m & (8'hff << (3'd7 - x2[2:0]));
        end
        return m;
    endfunction

    logic [9:0]        r_x1;
    logic [9:0]        r_x2;
    logic [8:0]        r_row;
    logic              r_ok;
    logic [7:0]        r_color;
    logic [BaseW-1:0]  r_base;
    logic [14:0]       r_word;
    logic signed [7:0] r_col;
    logic [CntW-1:0]   r_cnt;
    logic              r_valid;

    logic [9:0]         right;
    logic signed [16:0] xs;
    logic signed [16:0] xe;
    logic signed [16:0] rw;
    logic signed [16:0] lft;
    logic signed [16:0] rgt;
    logic signed [16:0] x1c;
    logic signed [16:0] x2c;
    logic               ok;
    logic [BaseW-1:0]   b1;
    logic [BaseW-1:0]   b2;
    logic [BaseW-1:0]   w1f;
    logic [BaseW-1:0]   diff;
    logic [3:0]         pen;
    logic [3:0]         pdat;
    logic signed [7:0]  col_odd;

    // Clip against the window and the bitmap's right edge.
    always_comb begin
        right = (i_cfg.clip_right > RightMax) ? RightMax : i_cfg.clip_right;
        xs    = {i_x_start[15], i_x_start};
        xe    = {i_x_end[15], i_x_end};
        rw    = {i_row[15], i_row};
        lft   = $signed({7'd0, i_cfg.clip_left});
        rgt   = $signed({7'd0, right});
        x1c   = (xs < lft) ? lft : xs;
        x2c   = (xe > rgt) ? rgt : xe;
        ok    = (rw >= $signed({8'd0, i_cfg.clip_top})) &&
                (rw <= $signed({8'd0, i_cfg.clip_bottom})) && (x1c <= x2c);
    end

    always_comb begin
        b1   = r_base + BaseW'(r_x1[9:3]);
        b2   = r_base + BaseW'(r_x2[9:3]);
        w1f  = b1 >> 1;
        diff = (b2 >> 1) - w1f;
    end

    always_comb begin
        if (i_cfg.plane_mode[7]) begin
            pen  = 4'hf;
            pdat = r_color[3:0];
        end else begin
            pen  = 4'b0001 << i_cfg.plane_mode[1:0];
            pdat = (r_color != 8'd0) ? pen : 4'h0;
        end
        col_odd = r_col + 8'sd1;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x1    <= x1c[9:0];
            r_x2    <= x2c[9:0];
            r_row   <= i_row[8:0];
            r_ok    <= ok;
            r_color <= i_color;
        end
        if (i_cmd.calc_base) begin
            r_base <= BaseW'(r_row) * RowBytesC + (i_cfg.top_page ? PageOff : '0);
        end
        if (i_cmd.calc_addr) begin
            r_word <= w1f[14:0];
            // The first word may start one byte left of the span's first byte.
            r_col  <= $signed({1'b0, r_x1[9:3]}) - $signed({7'd0, b1[0]});
            r_cnt  <= (diff > CapDiff) ? CntW'(MaxWrites - 1) : diff[CntW-1:0];
        end else if (i_cmd.emit) begin
            r_word <= r_word + 15'd1;
            r_col  <= r_col + 8'sd2;
            r_cnt  <= r_cnt - CntW'(1);
        end
        if (i_cmd.emit) begin
            o_word_offset  <= r_word;
            o_bank         <= i_cfg.bank_select;
            o_mask_even    <= byte_mask(r_col, r_x1, r_x2);
            o_mask_odd     <= byte_mask(col_odd, r_x1, r_x2);
            o_plane_enable <= pen;
            o_plane_data   <= pdat;
            o_last_write   <= (r_cnt == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
        end
    end

    assign o_valid       = r_valid;
    assign o_status.ok   = r_ok;
    assign o_status.last = (r_cnt == '0);

endmodule

FILE: rtl/clipped_planar_span_writer_unit.sv
// ----------------------------------------------------------------------------
// clipped_planar_span_writer_unit: span to masked planar VRAM word writes
// A span (x_start, x_end, row, color) is transferred at a rising edge where
// start is high and busy is low. The span is clipped to the view window and
// written as masked 16-bit word writes, left to right, one per cycle, each
// shown for one cycle with o_valid high; o_last_write marks the final one.
// The span passes the clip and address states; writes are registered. A span
// touches at most 40 words; busy is low while its last write is shown. A span
// off-window or empty after clipping produces no writes, and busy drops after
// the clip state. The rate is set by the single word walker, which emits one
// word per cycle. The configuration registers sit on the APB-style port at
// byte addresses 0 to 24 and take a write in its access cycle; they must be
// written only while busy is low and no write is pending; the block does not
// enforce this. Reset (synchronous, active low) returns the controller to
// idle, clears the strobe and loads the register reset values. Writes cannot
// be stalled by the receiver: each must be taken in the cycle it is shown.
// ----------------------------------------------------------------------------
module clipped_planar_span_writer_unit import cpsw_pkg::*; #(
    parameter int unsigned ROW_BYTES = 80
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] i_x_start,
    input  logic signed [15:0] i_x_end,
    input  logic signed [15:0] i_row,
    input  logic [7:0]         i_color,
    output logic               o_valid,
    output logic [14:0]        o_word_offset,
    output logic               o_bank,
    output logic [7:0]         o_mask_even,
    output logic [7:0]         o_mask_odd,
    output logic [3:0]         o_plane_enable,
    output logic [3:0]         o_plane_data,
    output logic               o_last_write,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [AddrW-1:0]   paddr,
    input  logic [DataW-1:0]   pwdata,
    output logic [DataW-1:0]   prdata,
    output logic               pready
);

    t_cfg    cfg;
    t_cmd    cmd;
    t_status status;

    cpsw_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    cpsw_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    cpsw_datapath #(
        .ROW_BYTES (ROW_BYTES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg          (cfg),
        .i_x_start      (i_x_start),
        .i_x_end        (i_x_end),
        .i_row          (i_row),
        .i_color        (i_color),
        .o_valid        (o_valid),
        .o_word_offset  (o_word_offset),
        .o_bank         (o_bank),
        .o_mask_even    (o_mask_even),
        .o_mask_odd     (o_mask_odd),
        .o_plane_enable (o_plane_enable),
        .o_plane_data   (o_plane_data),
        .o_last_write   (o_last_write)
    );

endmodule

FILE: rtl/cpsw_checker.sv
// ----------------------------------------------------------------------------
// cpsw_checker: port-level checks of the span writer
// Watches the command and write ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module cpsw_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_valid,
    input logic [7:0] o_mask_even,
    input logic [7:0] o_mask_odd,
    input logic [3:0] o_plane_enable,
    input logic [3:0] o_plane_data,
    input logic       o_last_write
);

    // No write is shown while a newly accepted span is in the clip and address states.
    a_no_early_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_valid ##1 !o_valid)
        else $error("write strobe too soon after a span transfer");

    // A burst of writes is contiguous until its last write.
    a_burst_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_write) |=> o_valid)
        else $error("gap inside a write burst");

    // The block is free again while the last write of a span is shown.
    a_idle_at_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_write) |-> !busy)
        else $error("still busy on the last write");

    // Data only on enabled planes, and every write touches a pixel.
    a_data_in_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_plane_data & ~o_plane_enable) == 4'h0))
        else $error("plane data outside enabled planes");

    a_mask_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_mask_even != 8'h00 || o_mask_odd != 8'h00))
        else $error("write with empty masks");

endmodule

bind clipped_planar_span_writer_unit cpsw_checker u_cpsw_checker (.*);

FILE: tb/testbench.sv
// ---------------------------------------------------------------------------
// Span writer bench: self-checking test of clipped_planar_span_writer_unit
// Spans enter through the start/busy handshake in bursts with random gaps.
// A behavioural predictor, or a directed entry, gives the masked word writes
// each accepted span should cause. Each strobed write is checked, field by
// field, against the oldest write still outstanding. Between phases the
// window, page, bank and plane mode are reprogrammed over APB and read back.
// ---------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import cpsw_pkg::*;

    localparam int RowBytes    = 80;
    localparam int NumPhases   = 11;
    localparam int PhaseItems  = 50;
    localparam int DrainCycles = 8;

    typedef struct packed {
        logic [14:0] word_offset;
        logic        bank;
        logic [7:0]  mask_even;
        logic [7:0]  mask_odd;
        logic [3:0]  plane_enable;
        logic [3:0]  plane_data;
        logic        last_write;
    } t_span_write;

    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_ONE
    } t_chk;

    typedef struct {
        logic [15:0] xs;
        logic [15:0] xe;
        logic [15:0] rw;
        logic [7:0]  color;
        t_chk        chk;
        t_span_write w;
    } t_span_vec;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [15:0] i_x_start = '0;
    logic signed [15:0] i_x_end = '0;
    logic signed [15:0] i_row = '0;
    logic [7:0]         i_color = '0;
    logic               o_valid;
    logic [14:0]        o_word_offset;
    logic               o_bank;
    logic [7:0]         o_mask_even;
    logic [7:0]         o_mask_odd;
    logic [3:0]         o_plane_enable;
    logic [3:0]         o_plane_data;
    logic               o_last_write;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [AddrW-1:0]   paddr = '0;
    logic [DataW-1:0]   pwdata = '0;
    logic [DataW-1:0]   prdata;
    logic               pready;

    t_cfg        cfg_model;
    t_span_write pending_writes [$];
    int          errors = 0;
    int          spans_sent = 0;
    int          spans_written = 0;
    int          writes_checked = 0;
    int          burst_left = 0;

    // Directed spans, all issued under the reset configuration.
    t_span_vec directed_spans [16] = '{
        '{16'd0,   16'd0,   16'd0,   8'h0F, CHK_ONE,
          {15'd0,     1'b0, 8'h80, 8'h00, 4'hF, 4'hF, 1'b1}},
        '{16'd639, 16'd639, 16'd399, 8'hFF, CHK_ONE,
          {15'd15999, 1'b0, 8'h00, 8'h01, 4'hF, 4'hF, 1'b1}},
        '{16'd8,   16'd8,   16'd0,   8'h06, CHK_ONE,
          {15'd0,     1'b0, 8'h00, 8'h80, 4'hF, 4'h6, 1'b1}},
        '{16'd5,   16'd10,  16'hFFFF, 8'hFF, CHK_NONE, '0},
        '{16'd5,   16'd10,  16'd400,  8'hFF, CHK_NONE, '0},
        '{16'd0,   16'd639, 16'h8000, 8'hFF, CHK_NONE, '0},
        '{16'd0,   16'd639, 16'h7FFF, 8'hFF, CHK_NONE, '0},
        '{16'd100, 16'd50,  16'd10,   8'hFF, CHK_NONE, '0},
        '{16'hFF9C, 16'hFFFF, 16'd10, 8'hFF, CHK_NONE, '0},
        '{16'd640, 16'd700, 16'd10,   8'hFF, CHK_NONE, '0},
        '{16'd0,    16'd639,  16'd0,   8'hA5, CHK_MODEL, '0},
        '{16'h8000, 16'h7FFF, 16'd200, 8'h3C, CHK_MODEL, '0},
        '{16'd3,    16'd12,   16'd5,   8'h01, CHK_MODEL, '0},
        '{16'd7,    16'd8,    16'd1,   8'h00, CHK_MODEL, '0},
        '{16'd15,   16'd16,   16'd2,   8'h0A, CHK_MODEL, '0},
        '{16'd16,   16'd31,   16'd399, 8'hF0, CHK_MODEL, '0}
    };

    clipped_planar_span_writer_unit #(
        .ROW_BYTES(RowBytes)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_x_start      (i_x_start),
        .i_x_end        (i_x_end),
        .i_row          (i_row),
        .i_color        (i_color),
        .o_valid        (o_valid),
        .o_word_offset  (o_word_offset),
        .o_bank         (o_bank),
        .o_mask_even    (o_mask_even),
        .o_mask_odd     (o_mask_odd),
        .o_plane_enable (o_plane_enable),
        .o_plane_data   (o_plane_data),
        .o_last_write   (o_last_write),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [7:0] pixel_mask(int col_byte, int lo, int hi);
        logic [7:0] m = '0;
        for (int i = 0; i < 8; i++) begin
            if (col_byte * 8 + i >= lo && col_byte * 8 + i <= hi) m[7-i] = 1'b1;
        end
        return m;
    endfunction

    // Clips one span to the current window and queues the word writes it
    // should cause, left to right.
    function automatic void plan_span_writes(logic [15:0] xs, logic [15:0] xe,
                                             logic [15:0] rw, logic [7:0] col);
        int          x1, x2, y, right, base, w1, w2, ce;
        logic [3:0]  pen, pdat;
        t_span_write wr;
        x1 = int'($signed(xs));
        x2 = int'($signed(xe));
        y  = int'($signed(rw));
        if (y < int'(cfg_model.clip_top) || y > int'(cfg_model.clip_bottom)) return;
        right = int'(cfg_model.clip_right);
        if (right > int'(ScreenCols) - 1) right = int'(ScreenCols) - 1;
        if (right > RowBytes * 8 - 1) right = RowBytes * 8 - 1;
        if (x1 < int'(cfg_model.clip_left)) x1 = int'(cfg_model.clip_left);
        if (x2 > right) x2 = right;
        if (x1 > x2) return;
        if (cfg_model.plane_mode[7]) begin
            pen  = 4'hF;
            pdat = col[3:0];
        end else begin
            pen  = 4'b0001 << cfg_model.plane_mode[1:0];
            pdat = (col != 8'h00) ? pen : 4'h0;
        end
        base = y * RowBytes + (cfg_model.top_page ? int'(PageBytes) : 0);
        w1 = (base + (x1 >>> 3)) >>> 1;
        w2 = (base + (x2 >>> 3)) >>> 1;
        if (w2 - w1 + 1 > int'(MaxWrites)) w2 = w1 + int'(MaxWrites) - 1;
        for (int w = w1; w <= w2; w++) begin
            ce = w * 2 - base;
            wr.word_offset  = w[14:0];
            wr.bank         = cfg_model.bank_select;
            wr.mask_even    = pixel_mask(ce, x1, x2);
            wr.mask_odd     = pixel_mask(ce + 1, x1, x2);
            wr.plane_enable = pen;
            wr.plane_data   = pdat;
            wr.last_write   = (w == w2);
            pending_writes.push_back(wr);
        end
    endfunction

    task automatic check_field(input string name, input logic [15:0] want_v,
                               input logic [15:0] got_v);
        if (got_v !== want_v) begin
            errors++;
            $display("[%0t] %s mismatch: expected 0x%0h, got 0x%0h",
                     $time, name, want_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin
        t_span_write want;
        if (i_rst_n && o_valid) begin
            if (pending_writes.size() == 0) begin
                errors++;
                $display("[%0t] write with nothing expected: offset 0x%0h",
                         $time, o_word_offset);
            end else begin
                want = pending_writes.pop_front();
                check_field("word_offset", 16'(want.word_offset), 16'(o_word_offset));
                check_field("bank", 16'(want.bank), 16'(o_bank));
                check_field("mask_even", 16'(want.mask_even), 16'(o_mask_even));
                check_field("mask_odd", 16'(want.mask_odd), 16'(o_mask_odd));
                check_field("plane_enable", 16'(want.plane_enable), 16'(o_plane_enable));
                check_field("plane_data", 16'(want.plane_data), 16'(o_plane_data));
                check_field("last_write", 16'(want.last_write), 16'(o_last_write));
                writes_checked++;
                if (want.last_write) spans_written++;
            end
        end
    end

    // Writes one register, then reads it back; the register keeps only its
    // own width of the written value.
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
        logic [31:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        want = '0;
        case (idx)
            REG_CLIP_LEFT: begin
                cfg_model.clip_left = value[9:0];
                want[9:0] = value[9:0];
            end
            REG_CLIP_RIGHT: begin
                cfg_model.clip_right = value[9:0];
                want[9:0] = value[9:0];
            end
            REG_CLIP_TOP: begin
                cfg_model.clip_top = value[8:0];
                want[8:0] = value[8:0];
            end
            REG_CLIP_BOTTOM: begin
                cfg_model.clip_bottom = value[8:0];
                want[8:0] = value[8:0];
            end
            REG_TOP_PAGE: begin
                cfg_model.top_page = value[0];
                want[0] = value[0];
            end
            REG_BANK_SELECT: begin
                cfg_model.bank_select = value[0];
                want[0] = value[0];
            end
            REG_PLANE_MODE: begin
                cfg_model.plane_mode = value[7:0];
                want[7:0] = value[7:0];
            end
            default: ;
        endcase
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) begin
            errors++;
            $display("[%0t] register %0d read back: expected 0x%0h, got 0x%0h",
                     $time, idx, want, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Presents one span and holds it until the transfer; start stays high
    // inside a burst and drops for a random gap between bursts.
    task automatic send_span(input logic [15:0] xs, input logic [15:0] xe,
                             input logic [15:0] rw, input logic [7:0] col,
                             input t_chk chk, input t_span_write typed_w);
        i_x_start <= xs;
        i_x_end   <= xe;
        i_row     <= rw;
        i_color   <= col;
        start     <= 1'b1;
        do @(posedge i_clk); while (busy);
        case (chk)
            CHK_MODEL: plan_span_writes(xs, xe, rw, col);
            CHK_ONE:   pending_writes.push_back(typed_w);
            CHK_NONE:  ;
            default:   ;
        endcase
        spans_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 6);
        end
    endtask

    initial begin
        logic [31:0] regs [7];
        logic [15:0] xs, xe, rw;
        logic [7:0]  col;
        int          sel, lo, len, items;
        cfg_model.clip_left   = 10'd0;
        cfg_model.clip_right  = 10'd639;
        cfg_model.clip_top    = 9'd0;
        cfg_model.clip_bottom = 9'd399;
        cfg_model.top_page    = 1'b0;
        cfg_model.bank_select = 1'b0;
        cfg_model.plane_mode  = 8'h80;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int p = 0; p < NumPhases; p++) begin
            if (p == 0) begin
                foreach (directed_spans[k])
                    send_span(directed_spans[k].xs, directed_spans[k].xe,
                              directed_spans[k].rw, directed_spans[k].color,
                              directed_spans[k].chk, directed_spans[k].w);
            end else begin
                case (p)
                    1: regs = '{32'd17, 32'd600, 32'd50, 32'd300, 32'd1, 32'd1, 32'h80};
                    2: regs = '{32'd0, 32'd1023, 32'd0, 32'd511, 32'd0, 32'd0, 32'h00};
                    3: regs = '{32'd639, 32'd639, 32'd399, 32'd399, 32'd1, 32'd1, 32'h7F};
                    // Window empty in both directions: nothing may be written.
                    4: regs = '{32'd500, 32'd100, 32'd300, 32'd100, 32'd0, 32'd1, 32'h83};
                    5: regs = '{32'd0, 32'd639, 32'd0, 32'd399, 32'd1, 32'd0, 32'h02};
                    10: foreach (regs[r]) regs[r] = $urandom;
                    default: begin
                        lo = $urandom_range(0, 639);
                        regs[0] = lo;
                        regs[1] = $urandom_range(lo, 1023);
                        lo = $urandom_range(0, 399);
                        regs[2] = lo;
                        regs[3] = $urandom_range(lo, 511);
                        regs[4] = $urandom_range(0, 1);
                        regs[5] = $urandom_range(0, 1);
                        regs[6] = $urandom_range(0, 255);
                    end
                endcase
                for (int r = 0; r < 7; r++) reg_write(r[2:0], regs[r]);
            end

            items = (p == 4) ? 15 : PhaseItems;
            for (int n = 0; n < items; n++) begin
                sel = $urandom_range(0, 99);
                if (sel < 60) begin
                    lo  = $urandom_range(0, 639);
                    len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 639)
                                                      : $urandom_range(0, 40);
                    xs  = 16'(lo);
                    xe  = 16'(lo + len);
                end else if (sel < 75) begin
                    xs = 16'(int'(cfg_model.clip_left) - int'($urandom_range(0, 20)));
                    xe = 16'(int'(cfg_model.clip_right) + 20 - int'($urandom_range(0, 40)));
                end else if (sel < 85) begin
                    lo = $urandom_range(0, 639);
                    xs = 16'(lo);
                    xe = 16'(lo - int'($urandom_range(1, 50)));
                end else begin
                    xs = 16'($urandom);
                    xe = 16'($urandom);
                end
                sel = $urandom_range(0, 99);
                if (sel < 75) begin
                    if (cfg_model.clip_top <= cfg_model.clip_bottom)
                        rw = 16'($urandom_range(cfg_model.clip_top, cfg_model.clip_bottom));
                    else
                        rw = 16'($urandom_range(0, 399));
                end else if (sel < 88) begin
                    case ($urandom_range(0, 3))
                        0: rw = 16'(int'(cfg_model.clip_top) - 1);
                        1: rw = 16'(int'(cfg_model.clip_bottom) + 1);
                        2: rw = 16'(cfg_model.clip_top);
                        default: rw = 16'(cfg_model.clip_bottom);
                    endcase
                end else begin
                    rw = 16'($urandom);
                end
                col = ($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
                send_span(xs, xe, rw, col, CHK_MODEL, '0);
            end

            // Let every outstanding write arrive and the block settle before
            // the registers are touched again.
            start <= 1'b0;
            do @(posedge i_clk); while (pending_writes.size() != 0 || busy);
            repeat (DrainCycles) @(posedge i_clk);
        end

        $display("Ran %0d spans over %0d window and plane settings.", spans_sent, NumPhases);
        $display("%0d spans produced writes; %0d word writes checked, %0d errors.",
                 spans_written, writes_checked, errors);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d writes still outstanding.", pending_writes.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/cpsw_pkg.sv
rtl/cpsw_regs.sv
rtl/cpsw_ctrl.sv
rtl/cpsw_datapath.sv
rtl/clipped_planar_span_writer_unit.sv
rtl/cpsw_checker.sv
tb/testbench.sv
